// ===== sv/fmsa_pkg.sv =====
package fmsa_pkg;

    // Field and accumulator widths
    localparam int VAL_W     = 16;   // Q4.12 inputs
    localparam int PROD_W    = 32;   // Q8.24 products and lane sums
    localparam int P2_W      = 61;   // squared products, never above 2^60
    localparam int SQ_W      = 63;   // lane square sums, 0 .. 2^63-1
    localparam int DIFF_W    = 64;   // s^2 - q
    localparam int HALF_SH   = 25;   // halve and move Q16.48 to Q24.24
    localparam int TERM_W    = DIFF_W - HALF_SH;
    localparam int SCORE_W   = 48;   // Q24.24 score
    localparam int SUM_W     = SCORE_W + 1;
    localparam int TOT_W     = SCORE_W + 2;
    localparam int BIAS_SH   = 12;   // Q4.12 to Q24.24

    localparam int LANES_MAX      = 8;
    localparam int EMBED_SIZE_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_INTERCEPT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT_WEIGHT = 2'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the incoming item
        logic mul_p;      // form v*x and w*x
        logic mul_sq;     // form (v*x)^2
        logic acc;        // update the row accumulators
        logic fin_start;  // clear cross sum, point at lane 0
        logic lane_sq;    // square the lane sum of the current lane
        logic lane_sub;   // subtract the lane square sum
        logic lane_acc;   // add the halved term to the cross sum
        logic lane_next;  // advance the lane pointer
        logic sum;        // first-order sum plus cross sum
        logic emit;       // add bias, clamp, load the output register, clear row
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;       // the held item closes the row
        logic lane_last;  // lane pointer is at the final lane
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

// ===== sv/fmsa_ctrl.sv =====
module fmsa_ctrl import fmsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_FSQ  = 4'd4;
    localparam logic [3:0] S_FSUB = 4'd5;
    localparam logic [3:0] S_FACC = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Take an item only while idle
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.last) begin
                    o_cmd.fin_start = 1'b1;
                    n_state         = S_FSQ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FSQ: begin
                o_cmd.lane_sq = 1'b1;
                n_state       = S_FSUB;
            end
            S_FSUB: begin
                o_cmd.lane_sub = 1'b1;
                n_state        = S_FACC;
            end
            S_FACC: begin
                o_cmd.lane_acc = 1'b1;
                if (i_sts.lane_last) begin
                    n_state = S_SUM;
                end else begin
                    o_cmd.lane_next = 1'b1;
                    n_state         = S_FSQ;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // One item in flight: an accepted item blocks the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while previous item still in work");

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result emitted into a stalled output register");

    // Final lane leads straight to the score sum
    a_lane_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.lane_acc && i_sts.lane_last) |=> (o_cmd.sum && !o_cmd.lane_sq))
        else $error("lane sweep did not end in the score sum");

endmodule

// ===== sv/fmsa_dpath.sv =====
module fmsa_dpath import fmsa_pkg::*; #(
    parameter int EMBED_SIZE = EMBED_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_skip,
    input  logic signed [VAL_W-1:0]     i_feature_value,
    input  logic signed [VAL_W-1:0]     i_linear_weight,
    input  logic signed [VAL_W-1:0]     i_factor [LANES_MAX],
    input  logic                        i_last,
    input  logic                        i_out_stall,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    output logic                        o_out_valid,
    output logic signed [SCORE_W-1:0]   o_score,
    output logic                        o_overflow
);

    localparam int LANE_W  = (EMBED_SIZE > 1) ? $clog2(EMBED_SIZE) : 1;
    localparam int CROSS_W = TERM_W + LANE_W;

    localparam logic signed [PROD_W-1:0]  LIN_MAX   = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0]  LIN_MIN   = {1'b1, {(PROD_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // Configuration registers
    logic                       r_add_icpt;
    logic signed [VAL_W-1:0]    r_icpt_w;

    // Held item
    logic                       r_skip;
    logic                       r_last;
    logic signed [VAL_W-1:0]    r_x;
    logic signed [VAL_W-1:0]    r_w;
    logic signed [VAL_W-1:0]    r_v [EMBED_SIZE];

    // Product stages
    logic signed [PROD_W-1:0]   r_wx;
    logic signed [PROD_W-1:0]   r_p [EMBED_SIZE];
    logic [P2_W-1:0]            r_p2 [EMBED_SIZE];
    logic signed [DIFF_W-1:0]   p_sq [EMBED_SIZE];

    // Row accumulators
    logic signed [PROD_W-1:0]   r_lin [EMBED_SIZE];
    logic [SQ_W-1:0]            r_sq [EMBED_SIZE];
    logic signed [SCORE_W-1:0]  r_first;
    logic                       r_sat;

    // Accumulator update logic
    logic signed [PROD_W:0]     lin_sum [EMBED_SIZE];
    logic signed [PROD_W-1:0]   n_lin [EMBED_SIZE];
    logic [EMBED_SIZE-1:0]      lin_ovf;
    logic [SQ_W:0]              sq_sum [EMBED_SIZE];
    logic [SQ_W-1:0]            n_sq [EMBED_SIZE];
    logic [EMBED_SIZE-1:0]      sq_ovf;
    logic signed [SUM_W-1:0]    first_sum;
    logic signed [SCORE_W-1:0]  n_first;
    logic                       first_ovf;

    // Row finish
    logic [LANE_W-1:0]          r_lane;
    logic signed [DIFF_W-1:0]   lane_prod;
    logic [SQ_W-1:0]            r_s2;
    logic [SQ_W-1:0]            r_qsel;
    logic signed [DIFF_W-1:0]   r_d;
    logic signed [TERM_W-1:0]   lane_term;
    logic signed [CROSS_W-1:0]  r_cross;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [TOT_W-1:0]    bias;
    logic signed [TOT_W-1:0]    total;
    logic signed [SCORE_W-1:0]  n_score;
    logic                       score_ovf;

    // Output register
    logic                       r_out_valid;
    logic signed [SCORE_W-1:0]  r_score;
    logic                       r_ovf;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_icpt <= 1'b1;
            r_icpt_w   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADD_INTERCEPT:    r_add_icpt <= i_cfg_data[0];
                CFG_INTERCEPT_WEIGHT: r_icpt_w   <= $signed(i_cfg_data[VAL_W-1:0]);
                default: ;
            endcase
        end
    end

    // Capture the item, then form products and squares
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_skip <= i_skip;
            r_last <= i_last;
            r_x    <= i_feature_value;
            r_w    <= i_linear_weight;
            for (int k = 0; k < EMBED_SIZE; k++) begin
                r_v[k] <= i_factor[k];
            end
        end
        if (i_cmd.mul_p) begin
            r_wx <= r_w * r_x;
            for (int k = 0; k < EMBED_SIZE; k++) begin
                r_p[k] <= r_v[k] * r_x;
            end
        end
        if (i_cmd.mul_sq) begin
            for (int k = 0; k < EMBED_SIZE; k++) begin
                r_p2[k] <= p_sq[k][P2_W-1:0];
            end
        end
    end

    // Square each lane product
    always_comb begin
        for (int k = 0; k < EMBED_SIZE; k++) begin
            p_sq[k] = r_p[k] * r_p[k];
        end
    end

    // Saturating accumulator sums
    always_comb begin
        for (int k = 0; k < EMBED_SIZE; k++) begin
            lin_sum[k] = {r_lin[k][PROD_W-1], r_lin[k]} + {r_p[k][PROD_W-1], r_p[k]};
            lin_ovf[k] = (lin_sum[k][PROD_W] != lin_sum[k][PROD_W-1]);
            if (lin_ovf[k]) begin
                n_lin[k] = lin_sum[k][PROD_W] ? LIN_MIN : LIN_MAX;
            end else begin
                n_lin[k] = lin_sum[k][PROD_W-1:0];
            end
            sq_sum[k] = {1'b0, r_sq[k]} + {{(SQ_W+1-P2_W){1'b0}}, r_p2[k]};
            sq_ovf[k] = sq_sum[k][SQ_W];
            n_sq[k]   = sq_ovf[k] ? {SQ_W{1'b1}} : sq_sum[k][SQ_W-1:0];
        end
        first_sum = {r_first[SCORE_W-1], r_first}
                  + {{(SUM_W-PROD_W){r_wx[PROD_W-1]}}, r_wx};
        first_ovf = (first_sum[SUM_W-1] != first_sum[SUM_W-2]);
        if (first_ovf) begin
            n_first = first_sum[SUM_W-1] ? SCORE_MIN : SCORE_MAX;
        end else begin
            n_first = first_sum[SCORE_W-1:0];
        end
    end

    // Row accumulators: update on a kept feature, clear on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            for (int k = 0; k < EMBED_SIZE; k++) begin
                r_lin[k] <= '0;
                r_sq[k]  <= '0;
            end
            r_first <= '0;
            r_sat   <= 1'b0;
        end else if (i_cmd.acc && !r_skip) begin
            for (int k = 0; k < EMBED_SIZE; k++) begin
                r_lin[k] <= n_lin[k];
                r_sq[k]  <= n_sq[k];
            end
            r_first <= n_first;
            r_sat   <= r_sat | first_ovf | (|lin_ovf) | (|sq_ovf);
        end
    end

    // Lane sweep: square, subtract, halve and add
    assign lane_prod = r_lin[r_lane] * r_lin[r_lane];
    assign lane_term = r_d[DIFF_W-1:HALF_SH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else if (i_cmd.fin_start) begin
            r_lane <= '0;
        end else if (i_cmd.lane_next) begin
            r_lane <= r_lane + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_start) begin
            r_cross <= '0;
        end else if (i_cmd.lane_acc) begin
            r_cross <= r_cross + {{LANE_W{lane_term[TERM_W-1]}}, lane_term};
        end
        if (i_cmd.lane_sq) begin
            r_s2   <= lane_prod[SQ_W-1:0];
            r_qsel <= r_sq[r_lane];
        end
        if (i_cmd.lane_sub) begin
            r_d <= $signed({1'b0, r_s2}) - $signed({1'b0, r_qsel});
        end
        if (i_cmd.sum) begin
            r_sum <= {r_first[SCORE_W-1], r_first}
                   + {{(SUM_W-CROSS_W){r_cross[CROSS_W-1]}}, r_cross};
        end
    end

    // Bias, final clamp
    always_comb begin
        if (r_add_icpt) begin
            bias = {{(TOT_W-VAL_W-BIAS_SH){r_icpt_w[VAL_W-1]}}, r_icpt_w, {BIAS_SH{1'b0}}};
        end else begin
            bias = '0;
        end
        total     = {r_sum[SUM_W-1], r_sum} + bias;
        score_ovf = (total[TOT_W-1] != total[SCORE_W-1])
                 || (total[TOT_W-2] != total[SCORE_W-1]);
        if (score_ovf) begin
            n_score = total[TOT_W-1] ? SCORE_MIN : SCORE_MAX;
        end else begin
            n_score = total[SCORE_W-1:0];
        end
    end

    // Output register: load on emit, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_score <= n_score;
            r_ovf   <= r_sat | score_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_overflow  = r_ovf;

    assign o_sts.last      = r_last;
    assign o_sts.lane_last = (r_lane == LANE_W'(EMBED_SIZE - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Row state is clean after every result
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_first == '0 && !r_sat && r_lin[0] == '0 && r_sq[0] == '0))
        else $error("row state not cleared after result");

    // Lane pointer stays inside the configured lanes
    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane <= LANE_W'(EMBED_SIZE - 1))
        else $error("lane pointer beyond last lane");

    // A result appears in the cycle after emit
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted result not shown as valid");

endmodule

// ===== sv/fm_score_accumulator_top.sv =====
// Second-order factorization machine scorer. Features of one sparse row
// arrive one item at a time; each carries a Q4.12 value, its linear weight
// and eight embedding factors (lanes at or above EMBED_SIZE are ignored),
// and items with skip set add nothing. The item flagged last produces one
// result: bias (when add_intercept is set) plus the linear sum plus half of
// the sum over lanes of (s^2 - q), as a saturated Q24.24 score with an
// overflow flag that reports any saturation in the row. The row state is
// then cleared. An item that does not end the row occupies the block through
// capture, product multiply, square multiply and accumulate; the last item
// of a row then adds the lane sweep, which runs one lane at a time through
// a single shared squaring multiplier, plus any wait for a previous result
// to be taken. Configuration writes take effect at once and belong between
// rows.
module fm_score_accumulator_top import fmsa_pkg::*; #(
    parameter int EMBED_SIZE = EMBED_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_skip,
    input  logic signed [VAL_W-1:0]     i_feature_value,
    input  logic signed [VAL_W-1:0]     i_linear_weight,
    input  logic signed [VAL_W-1:0]     i_factor_0,
    input  logic signed [VAL_W-1:0]     i_factor_1,
    input  logic signed [VAL_W-1:0]     i_factor_2,
    input  logic signed [VAL_W-1:0]     i_factor_3,
    input  logic signed [VAL_W-1:0]     i_factor_4,
    input  logic signed [VAL_W-1:0]     i_factor_5,
    input  logic signed [VAL_W-1:0]     i_factor_6,
    input  logic signed [VAL_W-1:0]     i_factor_7,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SCORE_W-1:0]   o_score,
    output logic                        o_overflow
);

    t_cmd                    cmd;
    t_sts                    sts;
    logic signed [VAL_W-1:0] factor [LANES_MAX];

    // Gather the factor lanes
    assign factor[0] = i_factor_0;
    assign factor[1] = i_factor_1;
    assign factor[2] = i_factor_2;
    assign factor[3] = i_factor_3;
    assign factor[4] = i_factor_4;
    assign factor[5] = i_factor_5;
    assign factor[6] = i_factor_6;
    assign factor[7] = i_factor_7;

    fmsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    fmsa_dpath #(
        .EMBED_SIZE (EMBED_SIZE)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_skip          (i_skip),
        .i_feature_value (i_feature_value),
        .i_linear_weight (i_linear_weight),
        .i_factor        (factor),
        .i_last          (i_last),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_score         (o_score),
        .o_overflow      (o_overflow)
    );

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmsa_pkg::*;

    localparam int     EMBED          = EMBED_SIZE_DEF;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     ITEMS_PER_PASS = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam longint SCORE_MAX = 64'sh0000_7fff_ffff_ffff;
    localparam longint SCORE_MIN = -SCORE_MAX - 1;
    localparam longint LANE_MAX  = 64'sd2147483647;
    localparam longint LANE_MIN  = -LANE_MAX - 1;
    localparam longint SQ_MAX    = 64'sh7fff_ffff_ffff_ffff;

    localparam logic [15:0] VMAX = 16'h7fff;
    localparam logic [15:0] VMIN = 16'h8000;

    localparam logic [7:0][15:0] V_NONE    = '0;
    localparam logic [7:0][15:0] V_ALL_MIN = {8{VMIN}};
    localparam logic [7:0][15:0] V_ALL_MAX = {8{VMAX}};
    localparam logic [7:0][15:0] V_HALF    = {8{16'h0800}};
    localparam logic [7:0][15:0] V_MIX     = {16'h1000, 16'hf000, 16'h0800, 16'hf800,
                                              16'h2000, 16'he000, 16'h0001, 16'hffff};

    typedef struct packed {
        logic             skip;
        logic             last;
        logic [15:0]      x;
        logic [15:0]      w;
        logic [7:0][15:0] v;
    } t_feature;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               ovf;
    } t_score;

    typedef struct packed {
        t_feature f;
        logic     typed;
        t_score   want;
    } t_dir_row;

    localparam t_score NO_SCORE = '0;

    // Directed rows; typed results apply with the reset configuration
    localparam t_dir_row DIR_TAB [22] = '{
        // row with nothing but a skipped feature
        '{'{1'b1, 1'b1, 16'h0000, 16'h0000, V_NONE},    1'b1, '{48'd0, 1'b0}},
        // zero value cancels every product
        '{'{1'b0, 1'b1, 16'h0000, VMAX, V_ALL_MIN},     1'b1, '{48'd0, 1'b0}},
        // smallest nonzero product
        '{'{1'b0, 1'b1, 16'h0001, 16'h0001, V_NONE},    1'b1, '{48'd1, 1'b0}},
        // a single feature has no pair term
        '{'{1'b0, 1'b1, VMIN, VMIN, V_ALL_MIN},         1'b1, '{48'h0000_4000_0000, 1'b0}},
        '{'{1'b0, 1'b1, VMAX, VMAX, V_ALL_MAX},         1'b1, '{48'd1073676289, 1'b0}},
        // opposite extremes across two features
        '{'{1'b0, 1'b0, VMAX, VMIN, V_ALL_MAX},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b1, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        // skipped feature inside a row
        '{'{1'b1, 1'b0, VMAX, VMAX, V_ALL_MAX},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b1, 16'h1000, 16'h2000, V_MIX},     1'b0, NO_SCORE},
        // skipped last feature still closes the row
        '{'{1'b0, 1'b0, 16'h1000, 16'hf000, V_HALF},    1'b0, NO_SCORE},
        '{'{1'b1, 1'b1, VMIN, VMIN, V_ALL_MIN},         1'b0, NO_SCORE},
        // lane sums clamp low on the third feature
        '{'{1'b0, 1'b0, VMIN, 16'h0000, V_ALL_MAX},     1'b0, NO_SCORE},
        '{'{1'b0, 1'b0, VMIN, 16'h0000, V_ALL_MAX},     1'b0, NO_SCORE},
        '{'{1'b0, 1'b1, VMIN, 16'h0000, V_ALL_MAX},     1'b0, NO_SCORE},
        // lane square sums clamp on the eighth feature, lane sums clamp high
        '{'{1'b0, 1'b0, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b0, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b0, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b0, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b0, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b0, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b0, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE},
        '{'{1'b0, 1'b1, VMIN, VMAX, V_ALL_MIN},         1'b0, NO_SCORE}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_skip;
    logic signed [VAL_W-1:0]   i_feature_value;
    logic signed [VAL_W-1:0]   i_linear_weight;
    logic signed [VAL_W-1:0]   i_factor_0;
    logic signed [VAL_W-1:0]   i_factor_1;
    logic signed [VAL_W-1:0]   i_factor_2;
    logic signed [VAL_W-1:0]   i_factor_3;
    logic signed [VAL_W-1:0]   i_factor_4;
    logic signed [VAL_W-1:0]   i_factor_5;
    logic signed [VAL_W-1:0]   i_factor_6;
    logic signed [VAL_W-1:0]   i_factor_7;
    logic                      i_last;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [SCORE_W-1:0] o_score;
    logic                      o_overflow;

    // Scorer mirror: configuration and row accumulators
    logic               cfg_bias_on = 1'b1;
    logic signed [15:0] cfg_bias_w  = '0;
    longint             lane_lin [LANES_MAX];
    longint             lane_sq  [LANES_MAX];
    longint             linear_sum;
    bit                 row_sat;

    t_score pending_scores [$];
    t_score oldest_score;
    int     errors       = 0;
    int     burst_left   = 0;
    bit     gaps_on      = 1'b1;
    int     stall_left   = 0;
    int     stall_mode   = 0;
    int     quiet_cycles = 0;

    fm_score_accumulator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_skip          (i_skip),
        .i_feature_value (i_feature_value),
        .i_linear_weight (i_linear_weight),
        .i_factor_0      (i_factor_0),
        .i_factor_1      (i_factor_1),
        .i_factor_2      (i_factor_2),
        .i_factor_3      (i_factor_3),
        .i_factor_4      (i_factor_4),
        .i_factor_5      (i_factor_5),
        .i_factor_6      (i_factor_6),
        .i_factor_7      (i_factor_7),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_score         (o_score),
        .o_overflow      (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_row(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            row_sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            row_sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic void clear_row();
        for (int k = 0; k < LANES_MAX; k++) begin
            lane_lin[k] = 0;
            lane_sq[k]  = 0;
        end
        linear_sum = 0;
        row_sat    = 1'b0;
    endfunction

    // Fold one feature into the row; returns 1 with the score when the row closes
    function automatic bit score_feature(input t_feature f, output t_score r);
        longint x;
        longint p;
        longint p2;
        longint total;
        int     k;
        r = NO_SCORE;
        if (!f.skip) begin
            x = longint'($signed(f.x));
            linear_sum = clamp_row(linear_sum + longint'($signed(f.w)) * x,
                                   SCORE_MIN, SCORE_MAX);
            for (k = 0; k < EMBED; k++) begin
                p  = longint'($signed(f.v[k])) * x;
                p2 = p * p;
                lane_lin[k] = clamp_row(lane_lin[k] + p, LANE_MIN, LANE_MAX);
                if (lane_sq[k] > SQ_MAX - p2) begin
                    lane_sq[k] = SQ_MAX;
                    row_sat    = 1'b1;
                end else begin
                    lane_sq[k] += p2;
                end
            end
        end
        if (!f.last) return 1'b0;
        // halve each pair term with a floor, then add linear part and bias
        total = linear_sum;
        for (k = 0; k < EMBED; k++)
            total += (lane_lin[k] * lane_lin[k] - lane_sq[k]) >>> HALF_SH;
        if (cfg_bias_on)
            total += longint'(cfg_bias_w) <<< BIAS_SH;
        total   = clamp_row(total, SCORE_MIN, SCORE_MAX);
        r.score = total[SCORE_W-1:0];
        r.ovf   = row_sat;
        clear_row();
        return 1'b1;
    endfunction

    // Mostly full-range values; hot rows stick to extremes, zero and values within one
    function automatic logic [15:0] pick_value(input bit hot);
        case ($urandom_range(0, hot ? 3 : 15))
            0:       return VMIN;
            1:       return VMAX;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 8191)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [SCORE_W-1:0] got,
                                   input logic [SCORE_W-1:0] want);
        $display("ERROR %0t ns: %s got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ADD_INTERCEPT:    cfg_bias_on = data[0];
            CFG_INTERCEPT_WEIGHT: cfg_bias_w  = data;
            default: ;
        endcase
    endtask

    // Offer one item, honoring bursts and gaps; predict once it is taken
    task automatic send_feature(input t_feature f, input logic typed, input t_score want);
        t_score r;
        int     gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_skip          <= f.skip;
        i_feature_value <= f.x;
        i_linear_weight <= f.w;
        i_factor_0      <= f.v[0];
        i_factor_1      <= f.v[1];
        i_factor_2      <= f.v[2];
        i_factor_3      <= f.v[3];
        i_factor_4      <= f.v[4];
        i_factor_5      <= f.v[5];
        i_factor_6      <= f.v[6];
        i_factor_7      <= f.v[7];
        i_last          <= f.last;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (score_feature(f, r))
            pending_scores.push_back(typed ? want : r);
    endtask

    // Random rows until the given number of unskipped items has gone in
    task automatic send_random_rows(input int n_items);
        t_feature f;
        int       len;
        int       i;
        int       k;
        bit       hot;
        while (n_items > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
            hot = ($urandom_range(0, 3) == 0);
            for (i = 0; i < len; i++) begin
                f.skip = ($urandom_range(0, 5) == 0);
                f.last = (i == len - 1);
                f.x    = pick_value(hot);
                f.w    = pick_value(hot);
                for (k = 0; k < LANES_MAX; k++)
                    f.v[k] = pick_value(hot);
                send_feature(f, 1'b0, NO_SCORE);
                if (!f.skip) n_items--;
            end
        end
    endtask

    // Drop valid, let every score come back, then let the lane sweep settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver stall: alternate between free, random, periodic and long stalls
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            2:       i_out_stall <= (stall_left % 7) < 4;
            default: i_out_stall <= (stall_left > 10);
        endcase
    end

    // Compare each taken score with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_scores.size() == 0) begin
                report_mismatch("unexpected score", o_score, '0);
            end else begin
                oldest_score = pending_scores.pop_front();
                if (o_score !== oldest_score.score)
                    report_mismatch("score", o_score, oldest_score.score);
                if (o_overflow !== oldest_score.ovf)
                    report_mismatch("overflow", 48'(o_overflow), 48'(oldest_score.ovf));
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall == 1'b0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR %0t ns: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_skip          = 1'b0;
        i_feature_value = '0;
        i_linear_weight = '0;
        i_factor_0      = '0;
        i_factor_1      = '0;
        i_factor_2      = '0;
        i_factor_3      = '0;
        i_factor_4      = '0;
        i_factor_5      = '0;
        i_factor_6      = '0;
        i_factor_7      = '0;
        i_last          = 1'b0;
        clear_row();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows under the reset configuration
        foreach (DIR_TAB[i])
            send_feature(DIR_TAB[i].f, DIR_TAB[i].typed, DIR_TAB[i].want);

        // random passes, each under its own bias setting
        for (n = 1; n <= 6; n++) begin
            wait_drained();
            case (n)
                1: begin
                    write_reg(CFG_ADD_INTERCEPT, 16'($urandom) | 16'h0001);
                    write_reg(CFG_INTERCEPT_WEIGHT, VMAX);
                    write_reg(CFG_SPARE_2, 16'($urandom));
                    write_reg(CFG_SPARE_3, 16'($urandom));
                end
                2: write_reg(CFG_INTERCEPT_WEIGHT, VMIN);
                3: begin
                    write_reg(CFG_ADD_INTERCEPT, 16'($urandom) & 16'hfffe);
                    write_reg(CFG_INTERCEPT_WEIGHT, 16'($urandom));
                end
                4: begin
                    write_reg(CFG_ADD_INTERCEPT, 16'hffff);
                    write_reg(CFG_INTERCEPT_WEIGHT, 16'($urandom));
                end
                5: begin
                    write_reg(CFG_ADD_INTERCEPT, 16'h0000);
                    write_reg(CFG_INTERCEPT_WEIGHT, VMAX);
                    write_reg(CFG_SPARE_3, 16'($urandom));
                end
                default: begin
                    write_reg(CFG_ADD_INTERCEPT, 16'h0001);
                    write_reg(CFG_INTERCEPT_WEIGHT, 16'($urandom));
                end
            endcase
            gaps_on = (n % 3) != 2;
            send_random_rows(ITEMS_PER_PASS);
        end

        wait_drained();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fmsa_pkg.sv
sv/fmsa_ctrl.sv
sv/fmsa_dpath.sv
sv/fm_score_accumulator_top.sv
sim/tb.sv
